### src/sbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types, codes and the CRC-16 byte update for the stuffed byte framer.
// ----------------------------------------------------------------------------
package sbf_pkg;

   // Action codes carried on the request tuser.
   typedef enum logic [1:0] {
      ACT_DATA    = 2'd0,
      ACT_COMMAND = 2'd1,
      ACT_END     = 2'd2,
      ACT_CRC     = 2'd3
   } sbf_action_type;

   // Configuration register indexes.
   localparam logic [1:0] REG_ESCAPE_CODE   = 2'd0;
   localparam logic [1:0] REG_COMMAND_CODE  = 2'd1;
   localparam logic [1:0] REG_ESCAPE_OFFSET = 2'd2;
   localparam logic [1:0] REG_CRC_START     = 2'd3;

   // Register reset values.
   localparam logic [7:0]  ESCAPE_CODE_RESET   = 8'hA5;
   localparam logic [7:0]  COMMAND_CODE_RESET  = 8'hA5;
   localparam logic [7:0]  ESCAPE_OFFSET_RESET = 8'h80;
   localparam logic [15:0] CRC_START_RESET     = 16'h0000;

   localparam logic [7:0]  XOFF_BYTE = 8'h13;
   localparam logic [15:0] CRC_POLY  = 16'hA001;

   // Framing registers seen by the expander.
   typedef struct packed {
      logic [7:0] escape_code;
      logic [7:0] command_code;
      logic [7:0] escape_offset;
   } sbf_cfg_type;

   // One transmitted byte.
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } sbf_byte_type;

   // Reflected CRC-16 over one byte, least significant bit first.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

endpackage

### src/sbf_crc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbf_crc
// Running CRC-16 over every byte entering the result register.
// ----------------------------------------------------------------------------
module sbf_crc
   import sbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [15:0] load_value,
   input  logic        push,
   input  logic [7:0]  push_byte,
   output logic [15:0] crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (load) begin
         crc_in = load_value;
      end else if (push) begin
         crc_in = crc16_byte(crc_ff, push_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_START_RESET;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

### src/sbf_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbf_expand
// Item register and byte expander: one or two framed bytes per action.
// ----------------------------------------------------------------------------
module sbf_expand
   import sbf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  sbf_action_type in_action,
   input  logic [7:0]     in_value,
   input  sbf_cfg_type    cfg,
   input  logic [15:0]    crc,
   input  logic           out_ready,
   output logic           out_valid,
   output sbf_byte_type   out_byte
);

   typedef enum logic [1:0] {
      PH_FIRST  = 2'b01,
      PH_SECOND = 2'b10
   } sbf_phase_type;

   logic           item_valid_ff, item_valid_in;
   sbf_action_type action_ff;
   logic [7:0]     value_ff;
   sbf_phase_type  phase_ff, phase_in;
   logic [7:0]     pending_ff;

   logic       escaped;
   logic       single;
   logic [7:0] first_byte;
   logic [7:0] second_byte;
   logic       push;
   logic       done;
   logic       accept;

   assign escaped = (value_ff == cfg.escape_code) || (value_ff == XOFF_BYTE);

   always_comb begin
      single      = 1'b0;
      first_byte  = cfg.escape_code;
      second_byte = cfg.escape_offset;
      case (action_ff)
         ACT_DATA: begin
            single      = !escaped;
            first_byte  = escaped ? cfg.escape_code : value_ff;
            second_byte = value_ff + cfg.escape_offset;
         end
         ACT_COMMAND: begin
            first_byte  = cfg.command_code;
            second_byte = value_ff;
         end
         ACT_END: begin
            first_byte  = cfg.escape_code;
            second_byte = cfg.escape_offset;
         end
         ACT_CRC: begin
            // take both bytes from the CRC held before this item
            first_byte  = crc[7:0];
            second_byte = crc[15:8];
         end
         default: begin
            first_byte = cfg.escape_code;
         end
      endcase
   end

   assign out_valid = item_valid_ff;
   assign push      = item_valid_ff && out_ready;
   assign done      = push && ((phase_ff == PH_SECOND) || single);
   assign in_ready  = !item_valid_ff || done;
   assign accept    = in_valid && in_ready;

   always_comb begin
      out_byte.tx_byte = (phase_ff == PH_SECOND) ? pending_ff : first_byte;
      out_byte.last    = (phase_ff == PH_SECOND) || single;
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      phase_in      = phase_ff;
      if (done) begin
         item_valid_in = 1'b0;
         phase_in      = PH_FIRST;
      end else if (push) begin
         phase_in = PH_SECOND;
      end
      if (accept) begin
         item_valid_in = 1'b1;
         phase_in      = PH_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= PH_FIRST;
      end else begin
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= in_action;
         value_ff  <= in_value;
      end
      if (push && (phase_ff == PH_FIRST)) begin
         pending_ff <= second_byte;
      end
   end

endmodule

### src/stuffed_byte_framer_crc16_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_byte_framer_crc16_unit
// Transmit framer with byte stuffing and a running reflected CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per action; tuser carries the action code, tdata the
//            data or command byte (ignored for end marker and CRC request).
//   rsp_*  : one item per transmitted byte; tlast marks the final byte that
//            an action causes.
//   csr_*  : register writes, always ready; write only while the framer is
//            idle. Writing crc_start presets the running CRC as well.
// Path: an accepted action waits in the expander's item register; its first
//   byte then enters the single result register and shows on rsp, and the
//   second byte follows as the first is taken. A plain data byte yields one
//   byte and every two-byte action two. An action is taken as the last byte
//   of the one before enters the result register, while earlier bytes wait.
// Reset: drops any held action and byte, restores the register reset values
//   and clears the running CRC to the crc_start reset value.
// Stall: while rsp_tready is low the result byte holds, the expander holds
//   its action, and req_tready falls once that action is held.
// ----------------------------------------------------------------------------
module stuffed_byte_framer_crc16_unit
   import sbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] value
   input  logic [1:0]  req_tuser,   // [1:0] action
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] tx_byte
   output logic        rsp_tlast,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   sbf_cfg_type  cfg_ff;
   logic         csr_write;
   logic         crc_load;
   logic [15:0]  crc;

   logic         exp_valid;
   sbf_byte_type exp_byte;
   logic         out_ready;
   logic         push;

   logic         rsp_valid_ff;
   sbf_byte_type rsp_byte_ff;

   // Register file: always ready; each write lands in its register.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign crc_load  = csr_write && (csr_index == REG_CRC_START);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.escape_code   <= ESCAPE_CODE_RESET;
         cfg_ff.command_code  <= COMMAND_CODE_RESET;
         cfg_ff.escape_offset <= ESCAPE_OFFSET_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_ESCAPE_CODE:   cfg_ff.escape_code   <= csr_wdata[7:0];
            REG_COMMAND_CODE:  cfg_ff.command_code  <= csr_wdata[7:0];
            REG_ESCAPE_OFFSET: cfg_ff.escape_offset <= csr_wdata[7:0];
            default: begin
               // crc_start goes straight into the running CRC
            end
         endcase
      end
   end

   // Expander: hold the action, hand out its bytes in order.
   sbf_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_action (sbf_action_type'(req_tuser)),
      .in_value  (req_tdata),
      .cfg       (cfg_ff),
      .crc       (crc),
      .out_ready (out_ready),
      .out_valid (exp_valid),
      .out_byte  (exp_byte)
   );

   // Advance the result register when empty or being taken.
   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign push      = exp_valid && out_ready;

   // Every byte entering the result register updates the CRC.
   sbf_crc u_crc (
      .clock      (clock),
      .reset      (reset),
      .load       (crc_load),
      .load_value (csr_wdata),
      .push       (push),
      .push_byte  (exp_byte.tx_byte),
      .crc        (crc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= exp_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_byte_ff <= exp_byte;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff.tx_byte;
   assign rsp_tlast  = rsp_byte_ff.last;

endmodule

### src/sbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbf_checker
// Port-level checks for the stuffed byte framer, bound to the top level.
// ----------------------------------------------------------------------------
module sbf_checker
   import sbf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A stalled byte holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result byte changed");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The second byte of an action follows its first with no gap and closes it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("second byte of an action missing or not last");

endmodule

bind stuffed_byte_framer_crc16_unit sbf_checker u_sbf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### tb/stuffed_byte_framer_crc16_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_byte_framer_crc16_unit_tb
// Self-checking regression for the stuffed byte framer. A framing model in
// the bench predicts every transmitted byte and the running CRC-16. A
// scoreboard compares each byte the framer sends against the oldest
// prediction. Traffic runs from directed frames through register extremes
// and a long output stall to randomised frames with random idling.
// ----------------------------------------------------------------------------
module stuffed_byte_framer_crc16_unit_tb;
   import sbf_pkg::*;

   // Watchdog limit, set well above the slowest legal run.
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 800;
   localparam int PHASE_ITEMS   = 100;
   localparam int HOLD_OFF_LEN  = 300;
   localparam int DRAIN_CYCLES  = 4;

   // Every input starts at a known value.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] value
   logic [1:0]  req_tuser  = ACT_DATA; // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;            // [7:0] tx_byte
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = REG_ESCAPE_CODE;
   logic [15:0] csr_wdata  = 16'h0000;

   // Framing model: register copies and the running CRC, at reset values.
   logic [7:0]  esc_code    = ESCAPE_CODE_RESET;
   logic [7:0]  cmd_code    = COMMAND_CODE_RESET;
   logic [7:0]  esc_offset  = ESCAPE_OFFSET_RESET;
   logic [15:0] crc_running = CRC_START_RESET;

   // Bytes predicted but not yet seen on the result stream, oldest first.
   sbf_byte_type tx_bytes_due[$];

   int fail_count   = 0;
   int cycle_count  = 0;
   bit gaps_on      = 1'b1;   // random idling on both sides
   int rsp_hold_off = 0;      // long receiver stall, counted down per cycle
   int rsp_gap      = 0;      // short receiver stall after each byte

   always #2 clock = ~clock;

   stuffed_byte_framer_crc16_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Framing model
   // -------------------------------------------------------------------------

   // Reflected CRC-16, one data bit at a time: the feedback bit is the
   // register LSB xored with the next data bit, LSB first.
   function automatic logic [15:0] crc16_shift(logic [15:0] crc, logic [7:0] b);
      logic [15:0] acc;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         acc = {1'b0, acc[15:1]} ^ ((acc[0] ^ b[i]) ? CRC_POLY : 16'h0000);
      end
      return acc;
   endfunction

   // Queue one transmitted byte and fold it into the running CRC.
   function automatic void queue_tx_byte(logic [7:0] b, logic is_last);
      sbf_byte_type entry;
      entry.tx_byte = b;
      entry.last    = is_last;
      tx_bytes_due.push_back(entry);
      crc_running = crc16_shift(crc_running, b);
   endfunction

   // Predict the bytes one accepted action produces.
   function automatic void frame_action(sbf_action_type action, logic [7:0] value);
      logic [15:0] crc_held;
      // Both CRC bytes come from the value held before either goes out.
      crc_held = crc_running;
      case (action)
         ACT_DATA: begin
            if (value == esc_code || value == XOFF_BYTE) begin
               queue_tx_byte(esc_code, 1'b0);
               queue_tx_byte(8'(value + esc_offset), 1'b1);
            end else begin
               queue_tx_byte(value, 1'b1);
            end
         end
         ACT_COMMAND: begin
            queue_tx_byte(cmd_code, 1'b0);
            queue_tx_byte(value, 1'b1);
         end
         ACT_END: begin
            queue_tx_byte(esc_code, 1'b0);
            queue_tx_byte(esc_offset, 1'b1);
         end
         default: begin
            queue_tx_byte(crc_held[7:0], 1'b0);
            queue_tx_byte(crc_held[15:8], 1'b1);
         end
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // Offer one action after a random gap; predict its bytes once accepted.
   // Valid is left high so that a back-to-back item follows with no gap.
   task automatic send_item(sbf_action_type action, logic [7:0] value);
      int gap;
      gap = gaps_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      frame_action(action, value);
   endtask

   // Drop valid and wait until every predicted byte has been seen, then let
   // the pipeline drain before anything touches the registers.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tx_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register; only called while the framer is idle.
   task automatic write_csr(logic [1:0] index, logic [15:0] wdata);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_ESCAPE_CODE:   esc_code   = wdata[7:0];
         REG_COMMAND_CODE:  cmd_code   = wdata[7:0];
         REG_ESCAPE_OFFSET: esc_offset = wdata[7:0];
         REG_CRC_START:     crc_running = wdata;   // preset takes effect at once
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_registers(logic [7:0] esc, logic [7:0] cmd, logic [7:0] off,
                                logic [15:0] crc);
      write_csr(REG_ESCAPE_CODE, {8'h00, esc});
      write_csr(REG_COMMAND_CODE, {8'h00, cmd});
      write_csr(REG_ESCAPE_OFFSET, {8'h00, off});
      write_csr(REG_CRC_START, crc);
   endtask

   // Register value biased towards the extremes.
   function automatic logic [7:0] pick_reg_byte();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Data byte biased towards the values that need stuffing.
   function automatic logic [7:0] pick_data_byte();
      case ($urandom_range(0, 9))
         0, 1, 2: return esc_code;
         3:       return XOFF_BYTE;
         default: return 8'($urandom);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Receiver: random stall after each byte, plus an occasional long hold-off
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold_off > 0) begin
         rsp_hold_off--;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && gaps_on) begin
         rsp_gap = $urandom_range(0, 9);
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Scoreboard: compare each accepted byte with the oldest prediction
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      sbf_byte_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tx_bytes_due.size() == 0) begin
            $error("tx_byte: expected none, actual %02h", rsp_tdata);
            fail_count++;
         end else begin
            due = tx_bytes_due.pop_front();
            if (rsp_tdata !== due.tx_byte) begin
               $error("tx_byte: expected %02h, actual %02h", due.tx_byte, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== due.last) begin
               $error("last: expected %0b, actual %0b", due.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stuffed_byte_framer_crc16_unit regression: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset register values: plain and stuffed data, commands, end, CRC.
   task automatic test_default_framing();
      send_item(ACT_DATA, 8'h00);
      send_item(ACT_DATA, 8'hFF);
      send_item(ACT_DATA, XOFF_BYTE);
      send_item(ACT_DATA, ESCAPE_CODE_RESET);
      send_item(ACT_COMMAND, 8'h00);
      send_item(ACT_COMMAND, 8'hFF);
      send_item(ACT_END, 8'hFF);
      send_item(ACT_CRC, 8'h00);
      settle();
   endtask

   // Register extremes, the escape code equal to XOFF, offset wrap and the
   // CRC preset seen straight away by a CRC request.
   task automatic test_register_extremes();
      set_registers(8'h00, 8'hFF, 8'hFF, 16'hFFFF);
      send_item(ACT_CRC, 8'hFF);
      send_item(ACT_DATA, 8'h00);
      send_item(ACT_DATA, XOFF_BYTE);
      send_item(ACT_COMMAND, 8'h5A);
      send_item(ACT_END, 8'h00);
      settle();
      set_registers(XOFF_BYTE, 8'h00, 8'h00, 16'h0000);
      send_item(ACT_DATA, XOFF_BYTE);
      send_item(ACT_DATA, 8'hFF);
      send_item(ACT_END, 8'h00);
      send_item(ACT_CRC, 8'h00);
      settle();
      set_registers(8'hFF, 8'hA5, 8'h01, 16'h8001);
      send_item(ACT_DATA, 8'hFF);
      send_item(ACT_CRC, 8'hFF);
      settle();
   endtask

   // Hold the receiver off for a long stretch while frames keep coming, so
   // the framer fills and stalls its input; then pause until all is seen.
   task automatic test_backpressure();
      gaps_on = 1'b0;
      set_registers(ESCAPE_CODE_RESET, COMMAND_CODE_RESET, ESCAPE_OFFSET_RESET,
                    16'($urandom));
      rsp_hold_off = HOLD_OFF_LEN;
      repeat (4) begin
         send_item(ACT_COMMAND, 8'($urandom));
         repeat (6) send_item(ACT_DATA, pick_data_byte());
         send_item(ACT_END, 8'($urandom));
         send_item(ACT_CRC, 8'($urandom));
      end
      settle();
      gaps_on = 1'b1;
   endtask

   // Mostly well-formed frames (command, data run, end, CRC) with random
   // content; the rest is loose actions that break frames up.
   task automatic test_random_traffic();
      int sent;
      int phase_items;
      int run_len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         set_registers(($urandom_range(0, 4) == 0) ? XOFF_BYTE : pick_reg_byte(),
                       pick_reg_byte(), pick_reg_byte(),
                       ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
         // Every third phase runs flat out on both sides.
         gaps_on = ((sent / PHASE_ITEMS) % 3) != 2;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
               run_len = $urandom_range(1, 12);
               send_item(ACT_COMMAND, 8'($urandom));
               repeat (run_len) send_item(ACT_DATA, pick_data_byte());
               send_item(ACT_END, 8'($urandom));
               send_item(ACT_CRC, 8'($urandom));
               phase_items += run_len + 3;
            end else begin
               send_item(sbf_action_type'($urandom_range(0, 3)), pick_data_byte());
               phase_items++;
            end
         end
         settle();
         sent += phase_items;
      end
      gaps_on = 1'b1;
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_framing();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      settle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("stuffed_byte_framer_crc16_unit regression: pass");
      end else begin
         $display("stuffed_byte_framer_crc16_unit regression: fail");
      end
      $finish;
   end

endmodule
